FILE: rtl/bft_pkg.sv
// Shared types, widths and codes of the block frequency test unit.
package bft_pkg;

  localparam int LEN_W       = 16;
  localparam int TOTAL_W     = 40;
  localparam int BLOCKS_W    = 32;
  localparam int SUM_W       = 64;
  localparam int ONES_W      = 17;
  localparam int DIFF_W      = 17;
  localparam int SQ_W        = 34;
  localparam int VBITS_W     = 7;
  localparam int DATA_W      = 64;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 160;
  localparam int CFG_DATA_W  = 40;

  localparam logic [LEN_W-1:0]   BLOCK_LEN_RESET = 16'd128;
  localparam logic [TOTAL_W-1:0] MIN_TOTAL_RESET = 40'd100;
  localparam int                 ENOUGH_FACTOR   = 100;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_FINISH = 1'b1
  } kind_e;

  typedef enum logic {
    CFG_BLOCK_LEN = 1'b0,
    CFG_MIN_TOTAL = 1'b1
  } cfg_idx_e;

  // Per-word control that travels alongside the lanes
  typedef struct packed {
    logic               vld;
    logic               fin;
    logic [TOTAL_W-1:0] total;
    logic [LEN_W-1:0]   fill;
    logic               enough;
  } meta_t;

  // Report word, square_sum in the lowest bits
  typedef struct packed {
    logic                enough;
    logic [LEN_W-1:0]    discarded;
    logic [TOTAL_W-1:0]  total;
    logic [BLOCKS_W-1:0] blocks;
    logic [SUM_W-1:0]    sum;
  } result_t;

endpackage

FILE: rtl/bft_segment.sv
// Block boundary finder: tracks the open block fill and marks where blocks close in a word.
module bft_segment #(
  parameter int WORD_BITS = 64,
  parameter int NUM_LANES = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                in_valid_i,
  input  logic                                kind_i,
  input  logic [bft_pkg::DATA_W-1:0]          data_i,
  input  logic [bft_pkg::VBITS_W-1:0]         valid_bits_i,
  input  logic [bft_pkg::LEN_W-1:0]           m_i,
  input  logic [bft_pkg::TOTAL_W-1:0]         min_total_i,
  output bft_pkg::meta_t                      meta_o,
  output logic [WORD_BITS-1:0]                word_o,
  output logic [$clog2(WORD_BITS+1)-1:0]      n_o,
  output logic [$clog2(WORD_BITS)-1:0]        pos_o [NUM_LANES],
  output logic [NUM_LANES-1:0]                close_o
);

  localparam int LW    = bft_pkg::LEN_W;
  localparam int TW    = bft_pkg::TOTAL_W;
  localparam int NB    = $clog2(WORD_BITS+1);
  localparam int IDX_W = $clog2(WORD_BITS);
  localparam int POS_W = LW + $clog2(NUM_LANES) + 1;

  logic [LW-1:0]    fill_q, fill_d;
  logic [TW-1:0]    bit_total_q, bit_total_d;
  logic [NB-1:0]    n;
  logic             is_data;
  logic [LW-1:0]    first_len;
  logic [POS_W-1:0] pos_full [NUM_LANES];
  logic [NUM_LANES-1:0] close_d;
  logic [TW:0]      total_sum;
  logic [TW-1:0]    m_scaled;
  logic             enough;
  bft_pkg::meta_t   meta_q;
  logic [WORD_BITS-1:0] word_q;
  logic [NB-1:0]    n_q;
  logic [IDX_W-1:0] pos_q [NUM_LANES];
  logic [NUM_LANES-1:0] close_q;

  // Clamp the valid-bit count to the word size
  assign n = (valid_bits_i > bft_pkg::VBITS_W'(WORD_BITS)) ? NB'(WORD_BITS)
                                                         : NB'(valid_bits_i);
  assign is_data = in_valid_i && (bft_pkg::kind_e'(kind_i) == bft_pkg::KIND_DATA);

  // Bits still needed by the open block; a block already at or past M closes on its next bit
  assign first_len = (fill_q >= m_i) ? LW'(1) : (m_i - fill_q);

  // Place the closing bit of each block in the word and derive the new fill
  always_comb begin
    fill_d = fill_q + LW'(n);
    for (int k = 0; k < NUM_LANES; k++) begin
      pos_full[k] = POS_W'(first_len) - POS_W'(1) + POS_W'(k) * POS_W'(m_i);
      close_d[k]  = is_data && (pos_full[k] < POS_W'(n));
      if (close_d[k]) begin
        fill_d = LW'(n) - LW'(pos_full[k]) - LW'(1);
      end
    end
  end

  // Saturating running bit count
  assign total_sum   = {1'b0, bit_total_q} + (TW+1)'(n);
  assign bit_total_d = total_sum[TW] ? {TW{1'b1}} : total_sum[TW-1:0];

  // Data sufficiency for a report
  assign m_scaled = TW'(m_i) * TW'(bft_pkg::ENOUGH_FACTOR);
  assign enough   = (bit_total_q >= min_total_i) && (bit_total_q >= m_scaled);

  // Hold block state, advance on each accepted data word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      bit_total_q <= '0;
    end else if (en_i && is_data) begin
      fill_q      <= fill_d;
      bit_total_q <= bit_total_d;
    end
  end

  // Stage control word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (en_i) begin
      meta_q.vld    <= in_valid_i;
      meta_q.fin    <= in_valid_i && !is_data;
      meta_q.total  <= bit_total_q;
      meta_q.fill   <= fill_q;
      meta_q.enough <= enough;
    end
  end

  // Stage word payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q  <= data_i[WORD_BITS-1:0];
      n_q     <= n;
      close_q <= close_d;
      for (int k = 0; k < NUM_LANES; k++) begin
        pos_q[k] <= pos_full[k][IDX_W-1:0];
      end
    end
  end

  assign meta_o  = meta_q;
  assign word_o  = word_q;
  assign n_o     = n_q;
  assign pos_o   = pos_q;
  assign close_o = close_q;

endmodule

FILE: rtl/bft_lane.sv
// One block lane: prefix popcount, |2*ones - M| and its square.
module bft_lane #(
  parameter int WORD_BITS = 64
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [WORD_BITS-1:0]            word_i,
  input  logic [$clog2(WORD_BITS)-1:0]    pos_i,
  input  logic                            close_i,
  input  logic [bft_pkg::LEN_W-1:0]       m_i,
  input  logic [bft_pkg::LEN_W-1:0]       ones_base_i,
  input  logic [$clog2(WORD_BITS+1)-1:0]  pc_sub_i,
  output logic [$clog2(WORD_BITS+1)-1:0]  pc_o,
  output logic                            close_r2_o,
  output logic [bft_pkg::SQ_W-1:0]        sq_o,
  output logic                            close_r4_o
);

  localparam int NB    = $clog2(WORD_BITS+1);
  localparam int IDX_W = $clog2(WORD_BITS);
  localparam int OW    = bft_pkg::ONES_W;
  localparam int DW    = bft_pkg::DIFF_W;
  localparam int SW    = bft_pkg::SQ_W;

  logic [NB-1:0] pc_d, pc_q;
  logic          cl2_q, cl3_q, cl4_q;
  logic [OW-1:0] ones;
  logic [OW:0]   twice, m_ext, diff_full;
  logic [DW-1:0] diff_q;
  logic [SW-1:0] sq_d, sq_q;

  // Count ones from bit 0 up to this lane's closing bit
  always_comb begin
    pc_d = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (IDX_W'(i) <= pos_i) begin
        pc_d = pc_d + NB'(word_i[i]);
      end
    end
  end

  // Ones of this block and the distance of twice that count from M
  assign ones      = OW'(ones_base_i) + OW'(pc_q) - OW'(pc_sub_i);
  assign twice     = {ones, 1'b0};
  assign m_ext     = (OW+1)'(m_i);
  assign diff_full = (twice >= m_ext) ? (twice - m_ext) : (m_ext - twice);

  // Square, dropped when the lane holds no block
  assign sq_d = cl3_q ? (SW'(diff_q) * SW'(diff_q)) : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc_q   <= pc_d;
      cl2_q  <= close_i;
      diff_q <= DW'(diff_full);
      cl3_q  <= cl2_q;
      sq_q   <= sq_d;
      cl4_q  <= cl3_q;
    end
  end

  assign pc_o       = pc_q;
  assign close_r2_o = cl2_q;
  assign sq_o       = sq_q;
  assign close_r4_o = cl4_q;

endmodule

FILE: rtl/bft_merge.sv
// Lane merge: sums the lane squares, keeps the saturating totals and holds the report word.
module bft_merge #(
  parameter int NUM_LANES = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  bft_pkg::meta_t             meta_i,
  input  logic [bft_pkg::SQ_W-1:0]   sq_i [NUM_LANES],
  input  logic [NUM_LANES-1:0]       close_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output bft_pkg::result_t           result_o,
  output logic                       hold_o
);

  localparam int CW  = $clog2(NUM_LANES+1);
  localparam int LSW = bft_pkg::SQ_W + CW;
  localparam int AW  = bft_pkg::SUM_W;
  localparam int BW  = bft_pkg::BLOCKS_W;

  logic [LSW-1:0]   lane_sum_d, lane_sum_q;
  logic [CW-1:0]    cnt_d, cnt_q;
  bft_pkg::meta_t   meta_q;
  logic [AW-1:0]    acc_q, acc_d;
  logic [AW:0]      acc_sum;
  logic [BW-1:0]    blk_q, blk_d;
  logic [BW:0]      blk_sum;
  logic             out_valid_q;
  bft_pkg::result_t result_q;

  // Add up the lanes
  always_comb begin
    lane_sum_d = '0;
    cnt_d      = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      lane_sum_d = lane_sum_d + LSW'(sq_i[k]);
      cnt_d      = cnt_d + CW'(close_i[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (en_i) begin
      meta_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_sum_q <= lane_sum_d;
      cnt_q      <= cnt_d;
    end
  end

  // Saturating accumulation
  assign acc_sum = {1'b0, acc_q} + (AW+1)'(lane_sum_q);
  assign acc_d   = acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];
  assign blk_sum = {1'b0, blk_q} + (BW+1)'(cnt_q);
  assign blk_d   = blk_sum[BW] ? {BW{1'b1}} : blk_sum[BW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      blk_q <= '0;
    end else if (en_i && meta_q.vld && !meta_q.fin) begin
      acc_q <= acc_d;
      blk_q <= blk_d;
    end
  end

  // Output register: load on a finish word, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i && meta_q.vld && meta_q.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && meta_q.vld && meta_q.fin) begin
      result_q.sum       <= acc_q;
      result_q.blocks    <= blk_q;
      result_q.total     <= meta_q.total;
      result_q.discarded <= meta_q.fill;
      result_q.enough    <= meta_q.enough;
    end
  end

  // Stall only when a report waits behind an unread one
  assign hold_o      = meta_q.vld && meta_q.fin && out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

FILE: rtl/block_frequency_test_unit.sv
// Top level of the block frequency test unit.
// Accepts one stream word per clock cycle (s_axis), bit 0 first, and cuts the
// stream into blocks of M = block_length bits (values below MIN_BLOCK act as
// MIN_BLOCK). Each closed block adds (2*ones - M)^2 to a saturating 64-bit
// sum; the chi-square statistic is that sum divided by M. A finish word (tuser
// set) yields one report word on m_axis: square sum, full blocks, total bits,
// bits of the open block and the enough-data flag.
// The rate of one word per cycle is set by the block boundary finder, which
// updates the open block fill per word; 1 + (WORD_BITS-1)/MIN_BLOCK
// lanes (four by default) score the blocks that close within one word. Data
// words keep flowing while a report waits; input stalls only when a second
// report reaches the output before the first is taken. Write configuration
// only while the unit is idle. No clearing pass is needed after reset.
module block_frequency_test_unit #(
  parameter int WORD_BITS = 64,
  parameter int MIN_BLOCK = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // s_axis_tdata: data_bits [63:0], valid_bits [70:64], zero [71]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bft_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // s_axis_tuser: kind [0]
  input  logic                               s_axis_tuser,
  // m_axis_tdata: square_sum [63:0], full_blocks [95:64], total_bits [135:96],
  //               discarded_bits [151:136], enough_data [152], zero [159:153]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bft_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [bft_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int NUM_LANES = 1 + (WORD_BITS - 1) / MIN_BLOCK;
  localparam int LW        = bft_pkg::LEN_W;
  localparam int TW        = bft_pkg::TOTAL_W;
  localparam int NB        = $clog2(WORD_BITS+1);
  localparam int IDX_W     = $clog2(WORD_BITS);
  localparam int SW        = bft_pkg::SQ_W;
  localparam int PAD_W     = bft_pkg::OUT_TDATA_W - $bits(bft_pkg::result_t);

  logic [LW-1:0]        block_length_q;
  logic [TW-1:0]        min_total_q;
  logic [LW-1:0]        m_eff;
  logic                 en;
  logic                 hold;

  bft_pkg::meta_t       r1_meta, r2_meta_q, r3_meta_q, r4_meta_q;
  logic [WORD_BITS-1:0] r1_word;
  logic [NB-1:0]        r1_n;
  logic [IDX_W-1:0]     r1_pos [NUM_LANES];
  logic [NUM_LANES-1:0] r1_close;

  logic [NB-1:0]        pc_w     [NUM_LANES];
  logic [LW-1:0]        ones_base [NUM_LANES];
  logic [NB-1:0]        pc_sub   [NUM_LANES];
  logic [NUM_LANES-1:0] close_r2;
  logic [SW-1:0]        sq_w     [NUM_LANES];
  logic [NUM_LANES-1:0] close_r4;

  logic [NB-1:0]        tot_d, tot_q;
  logic [NB-1:0]        pc_last;
  logic [LW-1:0]        carry_q, carry_d;

  bft_pkg::result_t     result;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= bft_pkg::BLOCK_LEN_RESET;
      min_total_q    <= bft_pkg::MIN_TOTAL_RESET;
    end else if (cfg_valid_i) begin
      case (bft_pkg::cfg_idx_e'(cfg_index_i))
        bft_pkg::CFG_BLOCK_LEN: block_length_q <= cfg_data_i[LW-1:0];
        bft_pkg::CFG_MIN_TOTAL: min_total_q    <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  assign m_eff = (block_length_q < LW'(MIN_BLOCK)) ? LW'(MIN_BLOCK) : block_length_q;

  // Whole pipeline advances together
  assign en            = !hold;
  assign s_axis_tready = en;

  bft_segment #(
    .WORD_BITS (WORD_BITS),
    .NUM_LANES (NUM_LANES)
  ) u_segment (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (s_axis_tvalid),
    .kind_i       (s_axis_tuser),
    .data_i       (s_axis_tdata[bft_pkg::DATA_W-1:0]),
    .valid_bits_i (s_axis_tdata[bft_pkg::DATA_W +: bft_pkg::VBITS_W]),
    .m_i          (m_eff),
    .min_total_i  (min_total_q),
    .meta_o       (r1_meta),
    .word_o       (r1_word),
    .n_o          (r1_n),
    .pos_o        (r1_pos),
    .close_o      (r1_close)
  );

  // Lanes, lane 0 continues the block left open by earlier words
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    if (k == 0) begin : g_first
      assign ones_base[k] = carry_q;
      assign pc_sub[k]    = '0;
    end else begin : g_next
      assign ones_base[k] = '0;
      assign pc_sub[k]    = pc_w[k-1];
    end

    bft_lane #(
      .WORD_BITS (WORD_BITS)
    ) u_lane (
      .clk_i       (clk_i),
      .en_i        (en),
      .word_i      (r1_word),
      .pos_i       (r1_pos[k]),
      .close_i     (r1_close[k]),
      .m_i         (m_eff),
      .ones_base_i (ones_base[k]),
      .pc_sub_i    (pc_sub[k]),
      .pc_o        (pc_w[k]),
      .close_r2_o  (close_r2[k]),
      .sq_o        (sq_w[k]),
      .close_r4_o  (close_r4[k])
    );
  end

  // Ones in the whole valid part of the word
  always_comb begin
    tot_d = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (NB'(i) < r1_n) begin
        tot_d = tot_d + NB'(r1_word[i]);
      end
    end
  end

  // Ones carried into the next word's open block
  always_comb begin
    pc_last = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      if (close_r2[k]) begin
        pc_last = pc_w[k];
      end
    end
    carry_d = (|close_r2) ? LW'(tot_q - pc_last) : (carry_q + LW'(tot_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else if (en && r2_meta_q.vld && !r2_meta_q.fin) begin
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tot_q <= tot_d;
    end
  end

  // Control word follows the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_meta_q <= '0;
      r3_meta_q <= '0;
      r4_meta_q <= '0;
    end else if (en) begin
      r2_meta_q <= r1_meta;
      r3_meta_q <= r2_meta_q;
      r4_meta_q <= r3_meta_q;
    end
  end

  bft_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .meta_i      (r4_meta_q),
    .sq_i        (sq_w),
    .close_i     (close_r4),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .result_o    (result),
    .hold_o      (hold)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, result};

  // Input stalls only behind a waiting report
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting report");

  // Blocks close in lane order within a word
  a_close_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r1_meta.vld |-> $onehot0(r1_close ^ (r1_close >> 1)))
    else $error("lane close flags not contiguous");

  // A finish word closes no block
  a_finish_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r1_meta.vld && r1_meta.fin) |-> (r1_close == '0))
    else $error("finish word marked a block close");

endmodule
